### rtl/core/rhsv_pkg.sv
// Shared constants, types and helpers for the RGB to HSV converter.
package rhsv_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int STEPS_PER_STAGE = 4;
  localparam int DIV_STAGES      = (FRAC_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int PIPE_STAGES     = DIV_STAGES + 4;
  localparam int OUT_W           = 16;
  localparam int CH_W            = 8;
  localparam int HDIV_W          = 11;

  localparam logic [OUT_W-1:0] SAT_FULL =
    (FRAC_BITS >= OUT_W) ? {OUT_W{1'b1}} : OUT_W'((1 << FRAC_BITS) - 1);

  typedef struct packed {
    logic [CH_W-1:0]      val;
    logic [CH_W-1:0]      sdiv;
    logic [CH_W-1:0]      srem;
    logic [FRAC_BITS-1:0] sq;
    logic [HDIV_W-1:0]    hdiv;
    logic [HDIV_W-1:0]    hrem;
    logic [FRAC_BITS-1:0] hq;
    logic                 szero;
    logic                 sfull;
    logic                 hzero;
  } div_t;

  function automatic logic [OUT_W-1:0] clamp_out(input logic [FRAC_BITS-1:0] q);
    return ((FRAC_BITS > OUT_W) && ((q >> OUT_W) != '0)) ? {OUT_W{1'b1}} : OUT_W'(q);
  endfunction

endpackage

### rtl/core/rgb_to_hsv_converter_core.sv
// Pipelined RGB to HSV converter top level.
//
// Usage:
//   Input channel  in_valid / in_stall carries one 8-bit RGB pixel per request.
//   Output channel out_valid / out_stall carries hue and saturation (Q0.16)
//   and value (the largest channel) per request.
//   A request moves at a rising edge with valid high and stall low.
//
// Timing:
//   Throughput is one pixel per clock while out_stall is low. The depth is
//   set by the two restoring dividers (saturation and hue), which retire
//   four quotient bits per stage.
//
// Stall and reset:
//   Each stage holds its own valid bit. A stalled output freezes only the
//   stages that are full behind it; empty stages keep filling, so in_stall
//   rises only when every stage holds a pixel. Nothing is lost or repeated.
//   Synchronous reset (rst_n low) clears all valid bits; the data registers
//   are left as they are.
module rgb_to_hsv_converter_core
  import rhsv_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CH_W-1:0]  in_red_in,
  input  logic [CH_W-1:0]  in_green_in,
  input  logic [CH_W-1:0]  in_blue_in,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [OUT_W-1:0] out_hue_out,
  output logic [OUT_W-1:0] out_sat_out,
  output logic [CH_W-1:0]  out_val_out
);

  // Sector of the largest channel, ties resolved red, then green.
  localparam logic [1:0] SEC_RED = 2'd0;
  localparam logic [1:0] SEC_GRN = 2'd1;
  localparam logic [1:0] SEC_BLU = 2'd2;

  // One group of restoring division steps for both quotients.
  function automatic div_t div_step(input div_t d, input int stage);
    div_t            o;
    logic [CH_W:0]   sr2;
    logic [HDIV_W:0] hr2;
    o = d;
    for (int i = 0; i < STEPS_PER_STAGE; i++) begin
      if (stage * STEPS_PER_STAGE + i < FRAC_BITS) begin
        sr2 = {o.srem, 1'b0};
        if (sr2 >= {1'b0, o.sdiv}) begin
          o.srem = CH_W'(sr2 - {1'b0, o.sdiv});
          o.sq   = {o.sq[FRAC_BITS-2:0], 1'b1};
        end else begin
          o.srem = sr2[CH_W-1:0];
          o.sq   = {o.sq[FRAC_BITS-2:0], 1'b0};
        end
        hr2 = {o.hrem, 1'b0};
        if (hr2 >= {1'b0, o.hdiv}) begin
          o.hrem = HDIV_W'(hr2 - {1'b0, o.hdiv});
          o.hq   = {o.hq[FRAC_BITS-2:0], 1'b1};
        end else begin
          o.hrem = hr2[HDIV_W-1:0];
          o.hq   = {o.hq[FRAC_BITS-2:0], 1'b0};
        end
      end
    end
    return o;
  endfunction

  // Per-stage valid bits and load enables.
  logic [PIPE_STAGES-1:0] v_r;
  logic [PIPE_STAGES:0]   en;

  always_comb begin
    en[PIPE_STAGES] = !out_stall;
    for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v_r[PIPE_STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < PIPE_STAGES; k++) begin
        if (en[k]) begin
          v_r[k] <= (k == 0) ? in_valid : v_r[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  // Stage 0: find max, min and the winning sector.
  logic [CH_W-1:0] s0_r_r, s0_g_r, s0_b_r, s0_hi_r, s0_lo_r;
  logic [1:0]      s0_sec_r;
  logic [CH_W-1:0] s0_hi_nxt, s0_lo_nxt;
  logic [1:0]      s0_sec_nxt;

  always_comb begin
    s0_hi_nxt = in_red_in;
    if (in_green_in > s0_hi_nxt) s0_hi_nxt = in_green_in;
    if (in_blue_in > s0_hi_nxt)  s0_hi_nxt = in_blue_in;
    s0_lo_nxt = in_red_in;
    if (in_green_in < s0_lo_nxt) s0_lo_nxt = in_green_in;
    if (in_blue_in < s0_lo_nxt)  s0_lo_nxt = in_blue_in;
    if (in_red_in >= in_green_in && in_red_in >= in_blue_in) begin
      s0_sec_nxt = SEC_RED;
    end else if (in_green_in >= in_blue_in) begin
      s0_sec_nxt = SEC_GRN;
    end else begin
      s0_sec_nxt = SEC_BLU;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_r_r   <= in_red_in;
      s0_g_r   <= in_green_in;
      s0_b_r   <= in_blue_in;
      s0_hi_r  <= s0_hi_nxt;
      s0_lo_r  <= s0_lo_nxt;
      s0_sec_r <= s0_sec_nxt;
    end
  end

  // Stage 1: range and the signed channel difference of the sector.
  logic [CH_W-1:0]   s1_hi_r, s1_rng_r;
  logic [1:0]        s1_sec_r;
  logic signed [8:0] s1_diff_r;
  logic signed [8:0] s1_diff_nxt;

  always_comb begin
    case (s0_sec_r)
      SEC_RED: s1_diff_nxt = $signed({1'b0, s0_g_r}) - $signed({1'b0, s0_b_r});
      SEC_GRN: s1_diff_nxt = $signed({1'b0, s0_b_r}) - $signed({1'b0, s0_r_r});
      default: s1_diff_nxt = $signed({1'b0, s0_r_r}) - $signed({1'b0, s0_g_r});
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_hi_r   <= s0_hi_r;
      s1_rng_r  <= s0_hi_r - s0_lo_r;
      s1_sec_r  <= s0_sec_r;
      s1_diff_r <= s1_diff_nxt;
    end
  end

  // Stage 2: hue numerator, wrap into one turn, set up both divisions.
  div_t               dv_r [0:DIV_STAGES];
  div_t               s2_nxt;
  logic signed [11:0] num_c;
  logic [HDIV_W-1:0]  rng6_c;

  always_comb begin
    rng6_c = HDIV_W'({s1_rng_r, 2'b00}) + HDIV_W'({s1_rng_r, 1'b0});
    case (s1_sec_r)
      SEC_RED: num_c = 12'sd0;
      SEC_GRN: num_c = $signed({3'b000, s1_rng_r, 1'b0});
      SEC_BLU: num_c = $signed({2'b00, s1_rng_r, 2'b00});
      default: num_c = 12'sd0;
    endcase
    num_c = num_c + {{3{s1_diff_r[8]}}, s1_diff_r};
    if (num_c < 0) begin
      num_c = num_c + $signed({1'b0, rng6_c});
    end
    s2_nxt.val   = s1_hi_r;
    s2_nxt.sdiv  = s1_hi_r;
    s2_nxt.szero = (s1_hi_r == '0);
    s2_nxt.sfull = (s1_rng_r == s1_hi_r) && (s1_hi_r != '0);
    s2_nxt.srem  = s2_nxt.sfull ? '0 : s1_rng_r;
    s2_nxt.sq    = '0;
    s2_nxt.hdiv  = rng6_c;
    s2_nxt.hzero = (s1_rng_r == '0);
    s2_nxt.hrem  = num_c[HDIV_W-1:0];
    s2_nxt.hq    = '0;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      dv_r[0] <= s2_nxt;
    end
    // Advance the division stages.
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (en[k+3]) begin
        dv_r[k+1] <= div_step(dv_r[k], k);
      end
    end
  end

  // Output register: apply special cases and clamp to 16 bits.
  always_ff @(posedge clk) begin
    if (en[PIPE_STAGES-1]) begin
      out_val_out <= dv_r[DIV_STAGES].val;
      if (dv_r[DIV_STAGES].szero) begin
        out_sat_out <= '0;
      end else if (dv_r[DIV_STAGES].sfull) begin
        out_sat_out <= SAT_FULL;
      end else begin
        out_sat_out <= clamp_out(dv_r[DIV_STAGES].sq);
      end
      out_hue_out <= dv_r[DIV_STAGES].hzero ? '0 : clamp_out(dv_r[DIV_STAGES].hq);
    end
  end

endmodule

### rtl/core/rhsv_checker.sv
// Port-level checker for the RGB to HSV converter, with its bind.
module rhsv_checker
  import rhsv_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [OUT_W-1:0] out_hue_out,
  input logic [OUT_W-1:0] out_sat_out,
  input logic [CH_W-1:0]  out_val_out
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A held request keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hue_out) &&
      $stable(out_sat_out) && $stable(out_val_out))
    else $error("stalled result changed");

  // An empty output stage never blocks the input.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with output empty");

  // Black gives zero saturation.
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_val_out == '0 |-> out_sat_out == '0)
    else $error("nonzero saturation on black");

  // Zero saturation means grey, and grey has hue zero.
  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sat_out == '0 |-> out_hue_out == '0)
    else $error("nonzero hue on grey");

endmodule

bind rgb_to_hsv_converter_core rhsv_checker u_rhsv_checker (.*);

### tb/tb.sv
// Self-checking testbench for the pipelined RGB to HSV converter core.
module tb;
  import rhsv_pkg::*;

  // One converted pixel, in the same widths as the result ports.
  typedef struct packed {
    logic [OUT_W-1:0] hue;
    logic [OUT_W-1:0] sat;
    logic [CH_W-1:0]  val;
  } hsv_t;

  localparam int RANDOM_PIXELS = 1125;
  localparam int DRAIN_CYCLES  = 2 * PIPE_STAGES + 4;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [CH_W-1:0]  in_red_in;
  logic [CH_W-1:0]  in_green_in;
  logic [CH_W-1:0]  in_blue_in;
  logic             out_valid;
  logic             out_stall;
  logic [OUT_W-1:0] out_hue_out;
  logic [OUT_W-1:0] out_sat_out;
  logic [CH_W-1:0]  out_val_out;

  // Conversions still owed by the pipeline, oldest first.
  hsv_t pending_hsv[$];

  int error_count   = 0;
  int pixels_sent   = 0;
  int pixels_seen   = 0;
  int black_pixels  = 0;
  int grey_pixels   = 0;
  int full_sat      = 0;
  int tied_max      = 0;

  // Sender burst state: requests left in the current burst.
  int burst_left    = 0;

  // Receiver stall pattern state.
  int stall_mode    = 0;
  int stall_left    = 0;
  int stall_cycle   = 0;

  rgb_to_hsv_converter_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_red_in   (in_red_in),
    .in_green_in (in_green_in),
    .in_blue_in  (in_blue_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_hue_out (out_hue_out),
    .out_sat_out (out_sat_out),
    .out_val_out (out_val_out)
  );

  // 10-unit clock period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Compute the expected HSV of one pixel. Value is the largest channel,
  // saturation is range/max and hue is picked by the sector of the largest
  // channel, with red checked first, then green, then blue.
  function automatic hsv_t predict_hsv(input logic [CH_W-1:0] r,
                                       input logic [CH_W-1:0] g,
                                       input logic [CH_W-1:0] b);
    hsv_t        res;
    logic [63:0] one;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] span;
    logic [63:0] sat_q;
    logic [63:0] hue_q;
    longint      num;
    one   = 64'd1 << FRAC_BITS;
    hi    = 64'(r);
    if (64'(g) > hi) hi = 64'(g);
    if (64'(b) > hi) hi = 64'(b);
    lo    = 64'(r);
    if (64'(g) < lo) lo = 64'(g);
    if (64'(b) < lo) lo = 64'(b);
    span  = hi - lo;
    sat_q = '0;
    hue_q = '0;

    // Black keeps zero saturation; exact 1.0 is pinned just below one.
    if (hi != 0) begin
      sat_q = (span << FRAC_BITS) / hi;
      if (sat_q >= one) sat_q = one - 64'd1;
    end

    // Grey keeps zero hue.
    if (span != 0) begin
      if (64'(r) == hi)
        num = longint'(g) - longint'(b);
      else if (64'(g) == hi)
        num = 2 * longint'(span) + longint'(b) - longint'(r);
      else
        num = 4 * longint'(span) + longint'(r) - longint'(g);
      // Wrap a negative red-sector numerator into a full turn.
      if (num < 0) num = num + 6 * longint'(span);
      hue_q = (64'(num) * one) / (64'd6 * span);
    end

    // Clamp to the port width for wide fraction settings.
    res.hue = (hue_q > 64'd65535) ? 16'hFFFF : hue_q[OUT_W-1:0];
    res.sat = (sat_q > 64'd65535) ? 16'hFFFF : sat_q[OUT_W-1:0];
    res.val = hi[CH_W-1:0];
    return res;
  endfunction

  // Send one pixel request. Hold the payload until the request is taken,
  // then record the expected result. At the end of a burst, drop valid for
  // a random gap that may be zero; otherwise leave valid high for the next request.
  task automatic send_pixel(input logic [CH_W-1:0] r,
                            input logic [CH_W-1:0] g,
                            input logic [CH_W-1:0] b);
    int gap;
    in_valid    <= 1'b1;
    in_red_in   <= r;
    in_green_in <= g;
    in_blue_in  <= b;
    do @(posedge clk); while (in_stall);
    pending_hsv.push_back(predict_hsv(r, g, b));
    pixels_sent++;
    if (r == 0 && g == 0 && b == 0) black_pixels++;
    if (r == g && g == b) grey_pixels++;
    else if (r == 0 || g == 0 || b == 0) full_sat++;
    if ((r == g && r >= b) || (g == b && g >= r) || (r == b && r >= g)) tied_max++;

    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // Pick the next burst; about a quarter of bursts run back to back.
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drive the result stall in randomly chosen modes: free running, light
  // random, periodic and heavy random back-pressure.
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(32, 200);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: begin
          out_stall <= 1'b0;
        end
        1: begin
          out_stall <= ($urandom_range(0, 9) < 3);
        end
        2: begin
          out_stall <= ((stall_cycle % 7) < 3);
        end
        default: begin
          out_stall <= ($urandom_range(0, 9) < 8);
        end
      endcase
    end
  end

  // Check every result taken from the output against the oldest expectation.
  // Sample at the edge, before the block updates, so order within the step
  // does not matter.
  always @(posedge clk) begin : result_checker
    hsv_t want;
    if (rst_n && out_valid && !out_stall) begin
      pixels_seen++;
      if (pending_hsv.size() == 0) begin
        error_count++;
        $display("%0t: result with none pending: hue %0d sat %0d val %0d",
                 $time, out_hue_out, out_sat_out, out_val_out);
      end else begin
        want = pending_hsv.pop_front();
        if (out_hue_out !== want.hue) begin
          error_count++;
          $display("%0t: hue mismatch: expected %0d, got %0d",
                   $time, want.hue, out_hue_out);
        end
        if (out_sat_out !== want.sat) begin
          error_count++;
          $display("%0t: sat mismatch: expected %0d, got %0d",
                   $time, want.sat, out_sat_out);
        end
        if (out_val_out !== want.val) begin
          error_count++;
          $display("%0t: val mismatch: expected %0d, got %0d",
                   $time, want.val, out_val_out);
        end
      end
    end
  end

  // Extremes: black, white, greys, primaries and the smallest nonzero pixels.
  task automatic test_corner_pixels();
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd1,   8'd1,   8'd1);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd0,   8'd0,   8'd1);
  endtask

  // Pixels in each hue sector, including a red-max pixel whose numerator
  // goes negative and wraps, and near-full-range pixels.
  task automatic test_hue_sectors();
    send_pixel(8'd200, 8'd100, 8'd50);
    send_pixel(8'd255, 8'd0,   8'd10);
    send_pixel(8'd50,  8'd200, 8'd100);
    send_pixel(8'd100, 8'd50,  8'd200);
    send_pixel(8'd10,  8'd20,  8'd255);
    send_pixel(8'd255, 8'd254, 8'd0);
    send_pixel(8'd170, 8'd85,  8'd1);
  endtask

  // Ties for the largest channel: red beats green, green beats blue.
  task automatic test_channel_ties();
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd128, 8'd128, 8'd7);
    send_pixel(8'd7,   8'd128, 8'd128);
    send_pixel(8'd128, 8'd7,   8'd128);
    send_pixel(8'd254, 8'd255, 8'd255);
  endtask

  // Random pixels, weighted toward the corners: greys, ties, a zero channel
  // and tiny values, on top of fully random bytes.
  task automatic test_random_pixels(input int count);
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    int              pick;
    repeat (count) begin
      r    = CH_W'($urandom);
      g    = CH_W'($urandom);
      b    = CH_W'($urandom);
      pick = $urandom_range(0, 9);
      case (pick)
        0: begin
          g = r;
          b = r;
        end
        1: begin
          g = r;
        end
        2: begin
          b = g;
        end
        3: begin
          case ($urandom_range(0, 2))
            0: r = '0;
            1: g = '0;
            default: b = '0;
          endcase
        end
        4: begin
          r = CH_W'($urandom_range(0, 3));
          g = CH_W'($urandom_range(0, 3));
          b = CH_W'($urandom_range(0, 3));
        end
        default: begin
        end
      endcase
      send_pixel(r, g, b);
    end
  endtask

  initial begin
    in_valid    <= 1'b0;
    in_red_in   <= '0;
    in_green_in <= '0;
    in_blue_in  <= '0;
    rst_n       <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corner_pixels();
    test_hue_sectors();
    test_channel_ties();
    test_random_pixels(RANDOM_PIXELS);

    // Drop valid and wait for the pipeline to empty.
    in_valid <= 1'b0;
    while (pending_hsv.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d pixels and checked %0d results under random stalls.",
             pixels_sent, pixels_seen);
    $display("Included %0d black, %0d grey, %0d fully saturated, %0d tied-max pixels.",
             black_pixels, grey_pixels, full_sat, tied_max);
    if (error_count == 0 && pending_hsv.size() == 0)
      $display("** rgb_to_hsv_converter_core: PASSED **");
    else
      $display("** rgb_to_hsv_converter_core: FAILED **");
    $finish;
  end

  // Watchdog: far beyond a fully stalled run of every request.
  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding.", pending_hsv.size());
    $display("** rgb_to_hsv_converter_core: FAILED **");
    $finish;
  end

endmodule
